/* src/rdpt_pkg.sv */
// ----------------------------------------------------------------------------
// rdpt_pkg
// Shared types, codes and defaults of the pending route discovery table.
// ----------------------------------------------------------------------------
package rdpt_pkg;

    localparam int DEF_TABLE_DEPTH   = 16;
    localparam int DEF_ATTEMPT_SLOTS = 3;

    localparam logic [31:0] RST_RETRY_FIRST = 32'd1000;
    localparam logic [31:0] RST_RETRY_LATER = 32'd2000;
    localparam logic [7:0]  RST_HOP_INIT    = 8'd5;
    localparam logic [7:0]  RST_HOP_EXP     = 8'd15;

    typedef enum logic [2:0] {
        OP_START      = 3'd0,
        OP_FIND_DEST  = 3'd1,
        OP_FIND_QUERY = 3'd2,
        OP_REMOVE     = 3'd3,
        OP_RECORD     = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_RETRY_FIRST = 2'd0,
        REG_RETRY_LATER = 2'd1,
        REG_HOP_INIT    = 2'd2,
        REG_HOP_EXP     = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [31:0] retry_first;
        logic [31:0] retry_later;
        logic [7:0]  hop_init;
        logic [7:0]  hop_exp;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [31:0] dest;
        logic [7:0]  attempts;
        logic [31:0] query;
        logic        due;
        logic [7:0]  hop;
    } t_result;

endpackage

/* src/rdpt_req_if.sv */
// ----------------------------------------------------------------------------
// rdpt_req_if
// Request channel: operation item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rdpt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] dest_address;
    logic [31:0] query_key;
    logic [31:0] time_now;

    modport source (
        output valid, operation, dest_address, query_key, time_now,
        input  ready
    );
    modport sink (
        input  valid, operation, dest_address, query_key, time_now,
        output ready
    );
endinterface

/* src/rdpt_rsp_if.sv */
// ----------------------------------------------------------------------------
// rdpt_rsp_if
// Response channel: result item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rdpt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] match_dest;
    logic [7:0]  attempt_count;
    logic [31:0] current_query;
    logic        retry_due;
    logic [7:0]  hop_budget;
    logic [4:0]  occupancy;

    modport source (
        output valid, status, match_dest, attempt_count, current_query,
               retry_due, hop_budget, occupancy,
        input  ready
    );
    modport sink (
        input  valid, status, match_dest, attempt_count, current_query,
               retry_due, hop_budget, occupancy,
        output ready
    );
endinterface

/* src/rdpt_cfg.sv */
// ----------------------------------------------------------------------------
// rdpt_cfg
// APB register file: retry intervals and hop limits.
// ----------------------------------------------------------------------------
module rdpt_cfg
    import rdpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_RETRY_FIRST: n_cfg.retry_first = pwdata;
                REG_RETRY_LATER: n_cfg.retry_later = pwdata;
                REG_HOP_INIT:    n_cfg.hop_init    = pwdata[7:0];
                REG_HOP_EXP:     n_cfg.hop_exp     = pwdata[7:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RETRY_FIRST: prdata = r_cfg.retry_first;
            REG_RETRY_LATER: prdata = r_cfg.retry_later;
            REG_HOP_INIT:    prdata = {24'd0, r_cfg.hop_init};
            REG_HOP_EXP:     prdata = {24'd0, r_cfg.hop_exp};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retry_first <= RST_RETRY_FIRST;
            r_cfg.retry_later <= RST_RETRY_LATER;
            r_cfg.hop_init    <= RST_HOP_INIT;
            r_cfg.hop_exp     <= RST_HOP_EXP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* src/rdpt_store.sv */
// ----------------------------------------------------------------------------
// rdpt_store
// Entry memories: one read port with registered data, one write port.
// ----------------------------------------------------------------------------
module rdpt_store
    import rdpt_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int ATTEMPT_SLOTS = DEF_ATTEMPT_SLOTS,
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int QW = ATTEMPT_SLOTS * 32
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_dest,
    output logic [31:0]   o_rd_time,
    output logic [7:0]    o_rd_att,
    output logic [QW-1:0] o_rd_queries,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_dest,
    input  logic [31:0]   i_wr_time,
    input  logic [7:0]    i_wr_att,
    input  logic [QW-1:0] i_wr_queries
);

    logic [31:0]   mem_dest    [TABLE_DEPTH];
    logic [31:0]   mem_time    [TABLE_DEPTH];
    logic [7:0]    mem_att     [TABLE_DEPTH];
    logic [QW-1:0] mem_queries [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_dest[i_wr_addr]    <= i_wr_dest;
            mem_time[i_wr_addr]    <= i_wr_time;
            mem_att[i_wr_addr]     <= i_wr_att;
            mem_queries[i_wr_addr] <= i_wr_queries;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_dest    <= mem_dest[i_rd_addr];
            o_rd_time    <= mem_time[i_rd_addr];
            o_rd_att     <= mem_att[i_rd_addr];
            o_rd_queries <= mem_queries[i_rd_addr];
        end
    end

endmodule

/* src/rdpt_ctrl.sv */
// ----------------------------------------------------------------------------
// rdpt_ctrl
// Sequencer: entry scan with shared compare unit, update, report, output hold.
// ----------------------------------------------------------------------------
module rdpt_ctrl
    import rdpt_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int ATTEMPT_SLOTS = DEF_ATTEMPT_SLOTS,
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int UW = $clog2(TABLE_DEPTH + 1),
    localparam int QW = ATTEMPT_SLOTS * 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [2:0]    i_in_operation,
    input  logic [31:0]   i_in_dest,
    input  logic [31:0]   i_in_query,
    input  logic [31:0]   i_in_time,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_result       o_out,
    output logic [4:0]    o_out_occ,
    output logic          o_rd_en,
    output logic [IW-1:0] o_rd_addr,
    input  logic [31:0]   i_rd_dest,
    input  logic [31:0]   i_rd_time,
    input  logic [7:0]    i_rd_att,
    input  logic [QW-1:0] i_rd_queries,
    output logic          o_wr_en,
    output logic [IW-1:0] o_wr_addr,
    output logic [31:0]   o_wr_dest,
    output logic [31:0]   o_wr_time,
    output logic [7:0]    o_wr_att,
    output logic [QW-1:0] o_wr_queries
);

    t_state        r_state,  n_state;
    t_op           r_op,     n_op;
    logic [31:0]   r_dest,   n_dest;
    logic [31:0]   r_query,  n_query;
    logic [31:0]   r_now,    n_now;
    logic [UW-1:0] r_used,   n_used;
    logic [UW-1:0] r_addr,   n_addr;
    logic [IW-1:0] r_chk,    n_chk;
    logic          r_dvalid, n_dvalid;
    logic [IW-1:0] r_hit,    n_hit;
    t_result       r_res,    n_res;
    logic          r_out_valid, n_out_valid;
    t_result       r_out,    n_out;
    logic [4:0]    r_out_occ, n_out_occ;

    logic          dest_hit;
    logic          query_hit;
    logic          match;
    logic [UW-1:0] last;
    logic          full;
    logic [7:0]    upd_att;
    logic [QW-1:0] upd_queries;
    logic [QW-1:0] start_queries;
    logic [31:0]   rep_dest;
    logic [7:0]    rep_att;
    logic [QW-1:0] rep_queries;
    logic [31:0]   rep_time;
    logic [7:0]    rep_slot;
    logic [31:0]   rep_query;
    logic [31:0]   rep_elapsed;
    logic [31:0]   rep_interval;
    t_result       rep;

    assign last = r_used - UW'(1);
    assign full = (r_used == UW'(TABLE_DEPTH));

    // compare unit: destination key and the used query slots of one entry
    always_comb begin
        dest_hit  = (i_rd_dest == r_dest);
        query_hit = 1'b0;
        for (int s = 0; s < ATTEMPT_SLOTS; s++) begin
            if ((8'(s) < i_rd_att) && (i_rd_queries[s*32 +: 32] == r_query)) begin
                query_hit = 1'b1;
            end
        end
        match = (r_op == OP_FIND_QUERY) ? query_hit : dest_hit;
    end

    always_comb begin
        upd_att       = (i_rd_att == 8'hFF) ? i_rd_att : i_rd_att + 8'd1;
        upd_queries   = i_rd_queries;
        start_queries = '0;
        start_queries[31:0] = r_query;
        for (int s = 0; s < ATTEMPT_SLOTS; s++) begin
            if (8'(s) == i_rd_att) begin
                upd_queries[s*32 +: 32] = r_query;
            end
        end
    end

    // report unit
    always_comb begin
        case (r_op)
            OP_START: begin
                rep_dest    = r_dest;
                rep_att     = 8'd1;
                rep_queries = start_queries;
                rep_time    = r_now;
            end
            OP_RECORD: begin
                rep_dest    = i_rd_dest;
                rep_att     = upd_att;
                rep_queries = upd_queries;
                rep_time    = r_now;
            end
            default: begin
                rep_dest    = i_rd_dest;
                rep_att     = i_rd_att;
                rep_queries = i_rd_queries;
                rep_time    = i_rd_time;
            end
        endcase
        rep_slot = (rep_att == 8'd0) ? 8'd0 : rep_att - 8'd1;
        if (rep_slot >= 8'(ATTEMPT_SLOTS)) begin
            rep_slot = 8'(ATTEMPT_SLOTS - 1);
        end
        rep_query = rep_queries[31:0];
        for (int s = 0; s < ATTEMPT_SLOTS; s++) begin
            if (rep_slot == 8'(s)) begin
                rep_query = rep_queries[s*32 +: 32];
            end
        end
        rep_elapsed  = r_now - rep_time;
        rep_interval = (rep_att <= 8'd1) ? i_cfg.retry_first : i_cfg.retry_later;
        rep.status   = STS_OK;
        rep.dest     = rep_dest;
        rep.attempts = rep_att;
        rep.query    = rep_query;
        rep.due      = (rep_att < 8'(ATTEMPT_SLOTS)) && (rep_elapsed >= rep_interval);
        rep.hop      = (rep_att <= 8'd1) ? i_cfg.hop_init : i_cfg.hop_exp;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_dest      = r_dest;
        n_query     = r_query;
        n_now       = r_now;
        n_used      = r_used;
        n_addr      = r_addr;
        n_chk       = r_chk;
        n_dvalid    = r_dvalid;
        n_hit       = r_hit;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_out_occ   = r_out_occ;
        o_in_ready  = 1'b0;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_addr[IW-1:0];
        o_wr_en     = 1'b0;
        o_wr_addr   = r_hit;
        o_wr_dest   = i_rd_dest;
        o_wr_time   = i_rd_time;
        o_wr_att    = i_rd_att;
        o_wr_queries = i_rd_queries;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op     = t_op'(i_in_operation);
                    n_dest   = i_in_dest;
                    n_query  = i_in_query;
                    n_now    = i_in_time;
                    n_addr   = '0;
                    n_dvalid = 1'b0;
                    n_res    = '0;
                    n_res.status = STS_NOT_FOUND;
                    case (t_op'(i_in_operation))
                        OP_START: n_state = ST_ACT;
                        OP_FIND_DEST, OP_FIND_QUERY, OP_REMOVE, OP_RECORD: begin
                            n_state = (r_used == '0) ? ST_RESULT : ST_SCAN;
                        end
                        default: n_state = ST_RESULT;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_dvalid && match) begin
                    n_hit   = r_chk;
                    n_state = ST_ACT;
                end else if (r_addr < r_used) begin
                    o_rd_en  = 1'b1;
                    n_chk    = r_addr[IW-1:0];
                    n_addr   = r_addr + UW'(1);
                    n_dvalid = 1'b1;
                end else if (!r_dvalid) begin
                    n_state = ST_RESULT;
                end else begin
                    n_dvalid = 1'b0;
                end
            end
            ST_ACT: begin
                n_state = ST_RESULT;
                case (r_op)
                    OP_START: begin
                        if (full) begin
                            n_res        = '0;
                            n_res.status = STS_FULL;
                        end else begin
                            o_wr_en      = 1'b1;
                            o_wr_addr    = r_used[IW-1:0];
                            o_wr_dest    = r_dest;
                            o_wr_time    = r_now;
                            o_wr_att     = 8'd1;
                            o_wr_queries = start_queries;
                            n_used       = r_used + UW'(1);
                            n_res        = rep;
                        end
                    end
                    OP_FIND_DEST, OP_FIND_QUERY: begin
                        n_res = rep;
                    end
                    OP_RECORD: begin
                        o_wr_en      = 1'b1;
                        o_wr_time    = r_now;
                        o_wr_att     = upd_att;
                        o_wr_queries = upd_queries;
                        n_res        = rep;
                    end
                    OP_REMOVE: begin
                        n_res = rep;
                        if (r_hit == last[IW-1:0]) begin
                            n_used = last;
                        end else begin
                            n_state = ST_MOVE_RD;
                        end
                    end
                    default: begin
                        n_res        = '0;
                        n_res.status = STS_NOT_FOUND;
                    end
                endcase
            end
            ST_MOVE_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = last[IW-1:0];
                n_state   = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                o_wr_en = 1'b1;
                n_used  = last;
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_out_occ   = 5'(r_used);
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_dvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_dvalid    <= n_dvalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_dest    <= n_dest;
        r_query   <= n_query;
        r_now     <= n_now;
        r_addr    <= n_addr;
        r_chk     <= n_chk;
        r_hit     <= n_hit;
        r_res     <= n_res;
        r_out     <= n_out;
        r_out_occ <= n_out_occ;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_out_occ   = r_out_occ;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != ST_IDLE))
        else $error("accepted item did not start work");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state == ST_ACT || r_state == ST_MOVE_WR))
        else $error("table write outside update states");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STS_FULL) |-> (r_out_occ == 5'(TABLE_DEPTH)))
        else $error("full status with table not full");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STS_NOT_FOUND)
            |-> (r_out.dest == '0 && r_out.attempts == '0 && r_out.hop == '0))
        else $error("miss result carries entry data");
`endif

endmodule

/* src/route_discovery_pending_table.sv */
// ----------------------------------------------------------------------------
// route_discovery_pending_table
// Packed table of pending route discoveries with start, find, remove and
// record-attempt operations.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+------------------------------------
//   i_req    | in  | valid/ready          | operation, dest, query, time
//   o_rsp    | out | valid/ready          | status, entry fields, occupancy
//   APB      | in  | psel/penable/pwrite  | paddr[3:2] register, pwdata
//
// Start passes the update state; searches scan the entries up to the hit or all
// in use and pass it on a hit; remove of a non-last entry adds a move read and
// a move write; all end in the result state. An empty-table search or unknown
// operation goes straight there. One memory read port, one entry per cycle,
// sets the scan. The input is ready again in the cycle the result is offered.
// Reset clears the control state only; entry contents are never cleared. One
// result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module route_discovery_pending_table
    import rdpt_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int ATTEMPT_SLOTS = DEF_ATTEMPT_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rdpt_req_if.sink    i_req,
    rdpt_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int QW = ATTEMPT_SLOTS * 32;

    t_cfg          cfg;
    t_result       out_res;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [31:0]   rd_dest;
    logic [31:0]   rd_time;
    logic [7:0]    rd_att;
    logic [QW-1:0] rd_queries;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_dest;
    logic [31:0]   wr_time;
    logic [7:0]    wr_att;
    logic [QW-1:0] wr_queries;

    rdpt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rdpt_store #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .ATTEMPT_SLOTS (ATTEMPT_SLOTS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rd_en      (rd_en),
        .i_rd_addr    (rd_addr),
        .o_rd_dest    (rd_dest),
        .o_rd_time    (rd_time),
        .o_rd_att     (rd_att),
        .o_rd_queries (rd_queries),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_dest    (wr_dest),
        .i_wr_time    (wr_time),
        .i_wr_att     (wr_att),
        .i_wr_queries (wr_queries)
    );

    rdpt_ctrl #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .ATTEMPT_SLOTS (ATTEMPT_SLOTS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_req.valid),
        .o_in_ready     (i_req.ready),
        .i_in_operation (i_req.operation),
        .i_in_dest      (i_req.dest_address),
        .i_in_query     (i_req.query_key),
        .i_in_time      (i_req.time_now),
        .o_out_valid    (o_rsp.valid),
        .i_out_ready    (o_rsp.ready),
        .o_out          (out_res),
        .o_out_occ      (o_rsp.occupancy),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_dest      (rd_dest),
        .i_rd_time      (rd_time),
        .i_rd_att       (rd_att),
        .i_rd_queries   (rd_queries),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_dest      (wr_dest),
        .o_wr_time      (wr_time),
        .o_wr_att       (wr_att),
        .o_wr_queries   (wr_queries)
    );

    assign o_rsp.status        = out_res.status;
    assign o_rsp.match_dest    = out_res.dest;
    assign o_rsp.attempt_count = out_res.attempts;
    assign o_rsp.current_query = out_res.query;
    assign o_rsp.retry_due     = out_res.due;
    assign o_rsp.hop_budget    = out_res.hop;

endmodule
